[hw/rtl/tsc_pkg.sv]
// Shared types and constants for the ternary search controller.
// No dependencies; imported by tsc_step, ternary_search_controller and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

  // Default widths of positions (signed Q16.16) and function values
  localparam int unsigned POS_WIDTH_DEF   = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Tolerance register
  localparam int unsigned      TOL_WIDTH = 31;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(66);

  // Item kind on the input channel
  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_VALUES = 1'b1;

  // Result kind on the output channel
  typedef enum logic [1:0] {
    KIND_PROBE      = 2'd0,
    KIND_DONE       = 2'd1,
    KIND_BADTOL     = 2'd2,
    KIND_UNEXPECTED = 2'd3
  } kind_e;

  // Search control flags kept between transactions
  typedef struct packed {
    logic searching;
    logic maximize;
  } ctrl_t;

endpackage : tsc_pkg

`default_nettype wire

[hw/rtl/ternary_search_controller.sv]
// Ternary search controller: top level with input register, state and result register.
// Depends on tsc_pkg and tsc_step.
`timescale 1ns / 1ps
`default_nettype none

// Ternary search for the extremum of a unimodal function evaluated outside the
// block. A start transaction (func 0) loads the interval ends, swapped if
// reversed, and the mode (seek_max 1 for a maximum, 0 for a minimum). While the
// span is at least the tolerance (and at least 3 LSBs) each step answers with a
// probe pair at one and two thirds of the interval; the caller evaluates f at
// both and returns the values in a value transaction (func 1), which narrows
// the interval. Once the span is small enough the answer is kind done with the
// mean of the last probes, rounded toward minus infinity. Every input
// transaction gives exactly one result. A zero tolerance on a start answers bad
// tolerance; values with no search running answer unexpected item and change
// nothing. Throughput is one transaction per clock while the output is not
// stalled; a transaction passes an input register, then one step of logic with
// a divide-by-three reciprocal multiply into the result register. The input
// side keeps accepting while a result waits, as long as the input register is
// empty or can drain into the result register. Write the tolerance (reset 66,
// Q16.16) only with no transaction in flight; it takes effect at the next edge.
module ternary_search_controller import tsc_pkg::*; #(
  parameter int unsigned POS_WIDTH   = POS_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration
  input  logic                          cfg_we_i,
  input  logic        [TOL_WIDTH-1:0]   cfg_wdata_i,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic signed [POS_WIDTH-1:0]   start_pos_i,
  input  logic signed [POS_WIDTH-1:0]   end_pos_i,
  input  logic                          seek_max_i,
  input  logic signed [VALUE_WIDTH-1:0] left_value_i,
  input  logic signed [VALUE_WIDTH-1:0] right_value_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic        [1:0]             kind_o,
  output logic signed [POS_WIDTH-1:0]   probe_left_o,
  output logic signed [POS_WIDTH-1:0]   probe_right_o,
  output logic signed [POS_WIDTH-1:0]   position_o
);

  // Offset-binary zero, i.e. position 0 in two's complement
  localparam logic [POS_WIDTH-1:0] POS_ZERO_B = {1'b1, {(POS_WIDTH-1){1'b0}}};

  // Tolerance register
  logic [TOL_WIDTH-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Handshake: the input register drains whenever the result register is free
  logic out_ready, s1_load, s1_move;
  logic s1_vld_q, s1_vld_d;
  logic out_vld_q, out_vld_d;

  assign out_ready  = !out_vld_q || !out_stall_i;
  assign s1_move    = s1_vld_q && out_ready;
  assign in_stall_o = s1_vld_q && !out_ready;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (s1_load) begin
      s1_vld_d = 1'b1;
    end else if (s1_move) begin
      s1_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (s1_move) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Input register: hold the accepted transaction until the step consumes it
  logic                          s1_func_q;
  logic signed [POS_WIDTH-1:0]   s1_start_q, s1_end_q;
  logic                          s1_seek_max_q;
  logic signed [VALUE_WIDTH-1:0] s1_left_q, s1_right_q;

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_func_q     <= func_i;
      s1_start_q    <= start_pos_i;
      s1_end_q      <= end_pos_i;
      s1_seek_max_q <= seek_max_i;
      s1_left_q     <= left_value_i;
      s1_right_q    <= right_value_i;
    end
  end

  // Search state, positions kept offset-binary so unsigned compares order them
  ctrl_t                ctrl_q, ctrl_d;
  logic [POS_WIDTH-1:0] low_q, low_d, high_q, high_d;
  logic [POS_WIDTH-1:0] probe_a_q, probe_a_d, probe_b_q, probe_b_d;

  kind_e                      step_kind;
  logic signed [POS_WIDTH-1:0] step_left, step_right, step_pos;

  tsc_step #(
    .POS_WIDTH   (POS_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_step (
    .func_i        (s1_func_q),
    .start_pos_i   (s1_start_q),
    .end_pos_i     (s1_end_q),
    .seek_max_i    (s1_seek_max_q),
    .left_value_i  (s1_left_q),
    .right_value_i (s1_right_q),
    .tolerance_i   (tol_q),
    .ctrl_i        (ctrl_q),
    .low_i         (low_q),
    .high_i        (high_q),
    .probe_a_i     (probe_a_q),
    .probe_b_i     (probe_b_q),
    .ctrl_o        (ctrl_d),
    .low_o         (low_d),
    .high_o        (high_d),
    .probe_a_o     (probe_a_d),
    .probe_b_o     (probe_b_d),
    .kind_o        (step_kind),
    .probe_left_o  (step_left),
    .probe_right_o (step_right),
    .position_o    (step_pos)
  );

  // Advance state only when the step's result goes into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q    <= '0;
      low_q     <= POS_ZERO_B;
      high_q    <= POS_ZERO_B;
      probe_a_q <= POS_ZERO_B;
      probe_b_q <= POS_ZERO_B;
    end else if (s1_move) begin
      ctrl_q    <= ctrl_d;
      low_q     <= low_d;
      high_q    <= high_d;
      probe_a_q <= probe_a_d;
      probe_b_q <= probe_b_d;
    end
  end

  // Result register
  kind_e                       kind_q;
  logic signed [POS_WIDTH-1:0] probe_left_q, probe_right_q, position_q;

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      kind_q        <= step_kind;
      probe_left_q  <= step_left;
      probe_right_q <= step_right;
      position_q    <= step_pos;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign kind_o        = kind_q;
  assign probe_left_o  = probe_left_q;
  assign probe_right_o = probe_right_q;
  assign position_o    = position_q;

  // While searching, the probes lie inside the interval in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.searching |-> (low_q <= probe_a_q) && (probe_a_q <= probe_b_q) &&
                         (probe_b_q <= high_q))
    else $error("probes outside interval while searching");

  // A probe pair result is ordered left to right
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_PROBE |-> probe_left_o <= probe_right_o)
    else $error("probe pair out of order");

  // The position field reads as zero on results that are not done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DONE |-> position_o == '0)
    else $error("position set on a result that is not done");

  // Emitting a probe pair leaves a search running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && step_kind == KIND_PROBE |=> ctrl_q.searching)
    else $error("probe pair issued without a running search");

  // A held transaction in the input register is not lost while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !s1_move |=> s1_vld_q && $stable(s1_func_q))
    else $error("stalled input transaction dropped");

endmodule : ternary_search_controller

`default_nettype wire

[hw/rtl/tsc_step.sv]
// One search step: start or narrow the interval, then emit probes or the result,
// or reject a bad start or stray values. Depends on tsc_pkg. Purely combinational; the top level registers around it.
`timescale 1ns / 1ps
`default_nettype none

module tsc_step import tsc_pkg::*; #(
  parameter int unsigned POS_WIDTH   = POS_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  // Item
  input  logic                           func_i,
  input  logic signed [POS_WIDTH-1:0]    start_pos_i,
  input  logic signed [POS_WIDTH-1:0]    end_pos_i,
  input  logic                           seek_max_i,
  input  logic signed [VALUE_WIDTH-1:0]  left_value_i,
  input  logic signed [VALUE_WIDTH-1:0]  right_value_i,
  input  logic        [TOL_WIDTH-1:0]    tolerance_i,
  // Current state, positions held offset-binary
  input  ctrl_t                          ctrl_i,
  input  logic        [POS_WIDTH-1:0]    low_i,
  input  logic        [POS_WIDTH-1:0]    high_i,
  input  logic        [POS_WIDTH-1:0]    probe_a_i,
  input  logic        [POS_WIDTH-1:0]    probe_b_i,
  // Next state
  output ctrl_t                          ctrl_o,
  output logic        [POS_WIDTH-1:0]    low_o,
  output logic        [POS_WIDTH-1:0]    high_o,
  output logic        [POS_WIDTH-1:0]    probe_a_o,
  output logic        [POS_WIDTH-1:0]    probe_b_o,
  // Result
  output kind_e                          kind_o,
  output logic signed [POS_WIDTH-1:0]    probe_left_o,
  output logic signed [POS_WIDTH-1:0]    probe_right_o,
  output logic signed [POS_WIDTH-1:0]    position_o
);

  localparam int unsigned SW = POS_WIDTH + 1;                 // span width
  localparam int unsigned CW = (SW > TOL_WIDTH) ? SW : TOL_WIDTH;
  // Even shift with 2^K >= 2*2^SW makes the reciprocal exact for every span
  localparam int unsigned K  = (SW % 2 == 1) ? SW + 1 : SW + 2;
  localparam logic [K:0]   POW      = {1'b1, {K{1'b0}}};
  localparam logic [K:0]   RECIP_W  = (POW + (K+1)'(2)) / (K+1)'(3);
  localparam logic [K-1:0] RECIP    = RECIP_W[K-1:0];
  localparam logic [POS_WIDTH-1:0] MSB = {1'b1, {(POS_WIDTH-1){1'b0}}};

  logic [POS_WIDTH-1:0] a_b, b_b;
  logic [POS_WIDTH-1:0] lo, hi, pa, pb;
  logic                 narrow_low;
  logic [SW-1:0]        span;
  logic                 keep;
  logic [SW+K-1:0]      prod;
  logic [SW-1:0]        third, rem, two_thirds;
  logic [SW-1:0]        pa_new, pb_new, pos_sum;

  assign a_b = start_pos_i ^ MSB;
  assign b_b = end_pos_i ^ MSB;
  assign narrow_low = ctrl_i.maximize ? (right_value_i > left_value_i)
                                      : (right_value_i < left_value_i);

  // Interval that the step works on: fresh ends on a start, narrowed otherwise
  always_comb begin
    lo = low_i;
    hi = high_i;
    pa = probe_a_i;
    pb = probe_b_i;
    if (func_i == FUNC_START) begin
      if (b_b < a_b) begin
        lo = b_b;
        hi = a_b;
      end else begin
        lo = a_b;
        hi = b_b;
      end
      pa = lo;
      pb = hi;
    end else if (narrow_low) begin
      lo = probe_a_i;
    end else begin
      hi = probe_b_i;
    end
  end

  // Span and divide by three through the reciprocal
  assign span       = SW'(hi) - SW'(lo);
  assign keep       = (CW'(span) >= CW'(tolerance_i)) && (span >= SW'(3));
  assign prod       = (SW+K)'(span) * (SW+K)'(RECIP);
  assign third      = prod[SW+K-1:K];
  assign rem        = span - ((third << 1) + third);
  assign two_thirds = (third << 1) + SW'(rem[1]);
  assign pa_new     = SW'(lo) + third;
  assign pb_new     = SW'(lo) + two_thirds;
  assign pos_sum    = SW'(pa) + SW'(pb);

  always_comb begin
    ctrl_o        = ctrl_i;
    low_o         = low_i;
    high_o        = high_i;
    probe_a_o     = probe_a_i;
    probe_b_o     = probe_b_i;
    kind_o        = KIND_PROBE;
    probe_left_o  = '0;
    probe_right_o = '0;
    position_o    = '0;
    if (func_i == FUNC_START && tolerance_i == '0) begin
      ctrl_o.searching = 1'b0;
      kind_o           = KIND_BADTOL;
    end else if (func_i == FUNC_VALUES && !ctrl_i.searching) begin
      kind_o = KIND_UNEXPECTED;
    end else begin
      if (func_i == FUNC_START) begin
        ctrl_o.maximize = seek_max_i;
      end
      low_o  = lo;
      high_o = hi;
      if (keep) begin
        ctrl_o.searching = 1'b1;
        probe_a_o        = pa_new[POS_WIDTH-1:0];
        probe_b_o        = pb_new[POS_WIDTH-1:0];
        kind_o           = KIND_PROBE;
        probe_left_o     = pa_new[POS_WIDTH-1:0] ^ MSB;
        probe_right_o    = pb_new[POS_WIDTH-1:0] ^ MSB;
      end else begin
        ctrl_o.searching = 1'b0;
        probe_a_o        = pa;
        probe_b_o        = pb;
        kind_o           = KIND_DONE;
        position_o       = pos_sum[POS_WIDTH:1] ^ MSB;
      end
    end
  end

endmodule : tsc_step

`default_nettype wire

[verif/tb_ternary_search_controller.sv]
// Self-checking testbench for ternary_search_controller: directed and random
// searches against a bit-accurate predictor, with random stalls on both sides.
// Depends on tsc_pkg and the RTL of ternary_search_controller.
`timescale 1ns / 1ps

module tb_ternary_search_controller;
  import tsc_pkg::*;

  localparam int PW = POS_WIDTH_DEF;
  localparam int VW = VALUE_WIDTH_DEF;
  // Random stimulus stops here; the last stretch runs with no idling
  localparam int RANDOM_END  = 560;
  localparam int ITEM_TOTAL  = 650;
  localparam int DRAIN_LIMIT = 2000;

  typedef logic signed [PW-1:0] pos_t;
  typedef logic signed [VW-1:0] val_t;

  localparam pos_t POS_MIN = {1'b1, {(PW-1){1'b0}}};
  localparam pos_t POS_MAX = ~POS_MIN;
  localparam val_t VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam val_t VAL_MAX = ~VAL_MIN;
  localparam logic [TOL_WIDTH-1:0] TOL_MAX = '1;

  // One result as the block should present it
  typedef struct {
    kind_e kind;
    pos_t  left;
    pos_t  right;
    pos_t  pos;
  } answer_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [TOL_WIDTH-1:0] cfg_wdata_i   = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic                 func_i        = FUNC_START;
  pos_t                 start_pos_i   = '0;
  pos_t                 end_pos_i     = '0;
  logic                 seek_max_i    = 1'b0;
  val_t                 left_value_i  = '0;
  val_t                 right_value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [1:0]           kind_o;
  pos_t                 probe_left_o;
  pos_t                 probe_right_o;
  pos_t                 position_o;

  ternary_search_controller #(
    .POS_WIDTH   (PW),
    .VALUE_WIDTH (VW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .start_pos_i   (start_pos_i),
    .end_pos_i     (end_pos_i),
    .seek_max_i    (seek_max_i),
    .left_value_i  (left_value_i),
    .right_value_i (right_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .probe_left_o  (probe_left_o),
    .probe_right_o (probe_right_o),
    .position_o    (position_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the search state, advanced once per accepted transaction
  pos_t                 lo_edge   = '0;
  pos_t                 hi_edge   = '0;
  pos_t                 probe_l   = '0;
  pos_t                 probe_r   = '0;
  logic                 busy      = 1'b0;
  logic                 want_max  = 1'b0;
  logic [TOL_WIDTH-1:0] tol_reg   = TOL_RESET;

  answer_t answer_q[$];

  int  items_sent      = 0;
  int  answers_checked = 0;
  int  fail_count      = 0;
  int  searches        = 0;
  int  tol_writes      = 0;
  int  kind_seen[4]    = '{0, 0, 0, 0};
  bit  quiet           = 1'b0;
  int  send_calm       = 0;
  int  stall_left      = 0;
  int  calm_left       = 0;

  function automatic void note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // Flip the sign bit: maps two's complement onto an order-preserving offset
  function automatic logic [PW-1:0] biased(input logic [PW-1:0] v);
    return v ^ POS_MIN;
  endfunction

  // Probe the current interval, or finish with the mean of the last probes.
  // The span is exact at PW+1 bits; the search also stops below a span of 3.
  function automatic answer_t settle_interval();
    logic [PW:0] span, third, two_thirds, lo_b, sum;
    answer_t     a;
    a.kind  = KIND_PROBE;
    a.left  = '0;
    a.right = '0;
    a.pos   = '0;
    lo_b = {1'b0, biased(lo_edge)};
    span = {1'b0, biased(hi_edge)} - lo_b;
    if (span >= tol_reg && span >= 3) begin
      third      = span / 3;
      two_thirds = 2 * third + (2 * (span % 3)) / 3;
      sum        = lo_b + third;
      probe_l    = biased(sum[PW-1:0]);
      sum        = lo_b + two_thirds;
      probe_r    = biased(sum[PW-1:0]);
      busy       = 1'b1;
      a.left     = probe_l;
      a.right    = probe_r;
    end else begin
      busy   = 1'b0;
      sum    = {1'b0, biased(probe_l)} + {1'b0, biased(probe_r)};
      a.kind = KIND_DONE;
      a.pos  = biased(sum[PW:1]);
    end
    return a;
  endfunction

  // Predict the result of one transaction and update the shadow state
  function automatic answer_t next_answer(input logic func, input pos_t sp, input pos_t ep,
                                          input logic fm, input val_t lv, input val_t rv);
    answer_t a;
    logic    move_low;
    a.kind  = KIND_UNEXPECTED;
    a.left  = '0;
    a.right = '0;
    a.pos   = '0;
    if (func == FUNC_START) begin
      if (tol_reg == '0) begin
        busy   = 1'b0;
        a.kind = KIND_BADTOL;
        return a;
      end
      want_max = fm;
      // Swap reversed ends
      if (ep < sp) begin
        lo_edge = ep;
        hi_edge = sp;
      end else begin
        lo_edge = sp;
        hi_edge = ep;
      end
      probe_l = lo_edge;
      probe_r = hi_edge;
      return settle_interval();
    end
    // Values with no search running change nothing
    if (!busy) return a;
    move_low = want_max ? (rv > lv) : (rv < lv);
    if (move_low) lo_edge = probe_l;
    else hi_edge = probe_r;
    return settle_interval();
  endfunction

  // Unimodal test function: peak (max mode) or valley (min mode) at peak
  function automatic val_t shape_at(input pos_t x, input pos_t peak);
    longint d;
    d = longint'(x) - longint'(peak);
    if (d < 0) d = -d;
    if (d > longint'(VAL_MAX)) d = longint'(VAL_MAX);
    return want_max ? val_t'(-d) : val_t'(d);
  endfunction

  // Drive one transaction at the falling edge and hold it until accepted
  task automatic send_item(input logic func, input pos_t sp, input pos_t ep,
                           input logic fm, input val_t lv, input val_t rv);
    int gap;
    if (!quiet) begin
      if (send_calm > 0) begin
        send_calm--;
      end else if ($urandom_range(0, 5) == 0) begin
        // Drop valid for a short burst
        gap = $urandom_range(1, 4);
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else if ($urandom_range(0, 9) == 0) begin
        send_calm = $urandom_range(10, 40);
      end
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    func_i        <= func;
    start_pos_i   <= sp;
    end_pos_i     <= ep;
    seek_max_i    <= fm;
    left_value_i  <= lv;
    right_value_i <= rv;
    do @(posedge clk_i); while (in_stall_o);
    answer_q.push_back(next_answer(func, sp, ep, fm, lv, rv));
    items_sent++;
  endtask

  task automatic send_start(input pos_t sp, input pos_t ep, input logic fm);
    send_item(FUNC_START, sp, ep, fm, val_t'($urandom), val_t'($urandom));
  endtask

  task automatic send_values(input val_t lv, input val_t rv);
    send_item(FUNC_VALUES, pos_t'($urandom), pos_t'($urandom), 1'($urandom), lv, rv);
  endtask

  // Answer probes with a unimodal function until the search ends
  task automatic finish_search(input pos_t peak);
    while (busy) send_values(shape_at(probe_l, peak), shape_at(probe_r, peak));
  endtask

  // Hold the input side until every predicted result has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write the tolerance with nothing in flight
  task automatic write_tolerance(input logic [TOL_WIDTH-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tol_reg   = v;
    tol_writes++;
  endtask

  // Values with no search running after reset
  task automatic test_values_while_idle();
    send_values(VAL_MIN, VAL_MAX);
    send_values(VAL_MAX, VAL_MIN);
  endtask

  // Full-range reversed ends in max mode; all three value orderings at extremes
  task automatic test_reversed_extremes();
    send_start(POS_MAX, POS_MIN, 1'b1);
    send_values(VAL_MIN, VAL_MAX);
    send_values(VAL_MAX, VAL_MAX);
    send_values(VAL_MAX, VAL_MIN);
    send_values(val_t'(0), val_t'(0));
  endtask

  // Abandon the running search with a new start in min mode
  task automatic test_restart_min();
    send_start(pos_t'(-100 <<< 16), pos_t'(100 <<< 16), 1'b0);
    send_values(val_t'(10), val_t'(-10));
    send_values(val_t'(-10), val_t'(10));
    send_values(val_t'(7), val_t'(7));
    finish_search(pos_t'(3 <<< 16));
  endtask

  // Spans below the stop limit answer done at once
  task automatic test_small_span();
    send_start(pos_t'(5), pos_t'(5), 1'b1);
    send_start(pos_t'(10), pos_t'(75), 1'b0);
    send_start(pos_t'(-4), pos_t'(-7), 1'b1);
    send_start(POS_MAX, POS_MAX, 1'b0);
    send_start(POS_MIN, POS_MIN, 1'b1);
  endtask

  // Zero tolerance rejects a start and ends the running search
  task automatic test_bad_tolerance();
    send_start(pos_t'(0), pos_t'(1 <<< 20), 1'b1);
    write_tolerance('0);
    send_start(pos_t'(0), pos_t'(1 <<< 20), 1'b1);
    send_values(val_t'(1), val_t'(2));
    send_start(POS_MIN, POS_MAX, 1'b0);
  endtask

  // Tolerance 1 and 2: the search must still stop at a span below 3
  task automatic test_resolution_floor();
    write_tolerance(TOL_WIDTH'(1));
    send_start(pos_t'(-1), pos_t'(2), 1'b1);
    finish_search(pos_t'(0));
    send_start(pos_t'(40), pos_t'(42), 1'b0);
    write_tolerance(TOL_WIDTH'(2));
    send_start(pos_t'(1000), pos_t'(1100), 1'b0);
    finish_search(pos_t'(1033));
  endtask

  // Largest tolerance: only a span of at least half the range gets probed
  task automatic test_wide_tolerance();
    write_tolerance(TOL_MAX);
    send_start(POS_MIN, POS_MAX, 1'b1);
    finish_search(pos_t'(12345));
    send_start(pos_t'(0), POS_MAX, 1'b0);
  endtask

  // One random search with a little noise, restarts and stray values
  task automatic run_search();
    pos_t        a, b, peak, t;
    int unsigned span;
    int          bits;
    bits = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 32) : $urandom_range(1, 24);
    span = (bits == 32) ? $urandom : $urandom_range(0, (1 << bits) - 1);
    a    = pos_t'($urandom);
    b    = a + pos_t'(span);
    peak = ($urandom_range(0, 7) == 0) ? pos_t'($urandom) : a + pos_t'($urandom_range(0, span));
    if ($urandom_range(0, 1) == 1) begin
      t = a;
      a = b;
      b = t;
    end
    searches++;
    send_start(a, b, 1'($urandom));
    while (busy) begin
      case ($urandom_range(0, 39))
        0: send_start(peak - pos_t'($urandom_range(0, 4000)),
                      peak + pos_t'($urandom_range(0, 4000)), 1'($urandom));
        1, 2: send_values(val_t'($urandom), val_t'($urandom));
        default: send_values(shape_at(probe_l, peak), shape_at(probe_r, peak));
      endcase
    end
    if ($urandom_range(0, 5) == 0) send_values(val_t'($urandom), val_t'($urandom));
  endtask

  // Phases of random searches, each under a fresh tolerance
  task automatic test_random_phases();
    logic [TOL_WIDTH-1:0] tol;
    while (items_sent < RANDOM_END) begin
      case ($urandom_range(0, 7))
        0: tol = TOL_WIDTH'(1);
        1: tol = TOL_WIDTH'(2);
        2: tol = TOL_WIDTH'(3);
        3: tol = TOL_RESET;
        4: tol = TOL_WIDTH'($urandom_range(4, 255));
        5: tol = TOL_WIDTH'($urandom_range(256, 1 << 20));
        6: tol = ($urandom_range(0, 1) == 1) ? TOL_MAX : TOL_WIDTH'($urandom);
        default: tol = '0;
      endcase
      write_tolerance(tol);
      repeat ($urandom_range(2, 6)) run_search();
      // Pause now and then until every result is back
      if ($urandom_range(0, 2) == 0) drain();
    end
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_quiet_tail();
    write_tolerance(TOL_RESET);
    quiet = 1'b1;
    while (items_sent < ITEM_TOTAL) run_search();
  endtask

  // Receiver stalls: short bursts, calm stretches, none in the tail
  always @(negedge clk_i) begin
    if (quiet || !rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else if (calm_left > 0) begin
      out_stall_i <= 1'b0;
      calm_left = calm_left - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: begin
          out_stall_i <= 1'b1;
          stall_left = $urandom_range(0, 3);
        end
        2: begin
          out_stall_i <= 1'b0;
          calm_left = $urandom_range(10, 40);
        end
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_answers
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answer_q.size() == 0) begin
        note_fail($sformatf("result with nothing pending, kind %0d", kind_o));
      end else begin
        want = answer_q.pop_front();
        answers_checked++;
        kind_seen[kind_o]++;
        if (kind_o !== want.kind || probe_left_o !== want.left ||
            probe_right_o !== want.right || position_o !== want.pos)
          note_fail($sformatf({"result %0d: want kind %s left %h right %h pos %h,",
                               " got kind %0d left %h right %h pos %h"},
                              answers_checked, want.kind.name(), want.left, want.right,
                              want.pos, kind_o, probe_left_o, probe_right_o, position_o));
      end
    end
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int waited;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_values_while_idle();
    test_reversed_extremes();
    test_restart_min();
    test_small_span();
    test_bad_tolerance();
    test_resolution_floor();
    test_wide_tolerance();
    test_random_phases();
    test_quiet_tail();

    // Wait out the pipeline, bounded
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    waited = 0;
    while (answer_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (5) @(posedge clk_i);
    if (answer_q.size() != 0)
      note_fail($sformatf("%0d results never arrived", answer_q.size()));

    $display("Run covered %0d transactions over %0d random searches and %0d tolerance writes.",
             items_sent, searches, tol_writes);
    $display("Results: %0d probe pairs, %0d done, %0d bad tolerance, %0d unexpected; %0d errors.",
             kind_seen[KIND_PROBE], kind_seen[KIND_DONE], kind_seen[KIND_BADTOL],
             kind_seen[KIND_UNEXPECTED], fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
